[rtl/core/substring_search_case_fold_core_assert.svh]
// Assertion macros for the substring search core.
`ifndef SUBSTRING_SEARCH_CASE_FOLD_CORE_ASSERT_SVH
`define SUBSTRING_SEARCH_CASE_FOLD_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SSCF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sscf: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SSCF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sscf: next-cycle check failed");

`endif

[rtl/core/sscf_pkg.sv]
// Types, constants and helpers shared by the substring search core.
`default_nettype none

package sscf_pkg;

  localparam int NEEDLE_BYTES = 16;
  localparam int LEN_W        = 5;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 64;
  localparam int RES_POS_W    = 32;

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_OFFSET  = 8'd32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NEEDLE_LOW     = 3'd0,
    CFG_NEEDLE_HIGH    = 3'd1,
    CFG_NEEDLE_LENGTH  = 3'd2,
    CFG_EXACT_MATCH    = 3'd3,
    CFG_START_POSITION = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic                 found;
    logic [RES_POS_W-1:0] match_position;
  } out_item_t;

  // Fold ASCII upper case to lower case when enabled.
  function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic fold_en);
    logic [7:0] r;
    r = c;
    if (fold_en && (c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z)) begin
      r = c + CASE_OFFSET;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/core/sscf_match.sv]
// Parallel needle compare against the byte window for every needle length.
`default_nettype none

module sscf_match
  import sscf_pkg::*;
#(
  parameter int MAX_NEEDLE = 16,
  parameter int WIN_D      = 15
) (
  input  var logic [7:0]                win_i [WIN_D+1],
  input  var logic [NEEDLE_BYTES*8-1:0] needle_i,
  input  var logic [LEN_W-1:0]          len_i,
  input  var logic                      fold_en_i,
  output logic                          hit_o
);

  localparam int LEN_SPAN = 2 ** LEN_W;

  logic [LEN_SPAN-1:0] hit_len;

  // win_i[0] is the current byte; needle byte j lines up with win_i[L-1-j].
  for (genvar gl = 0; gl < LEN_SPAN; gl++) begin : g_len
    if (gl >= 1 && gl <= NEEDLE_BYTES && gl <= MAX_NEEDLE) begin : g_on
      logic [gl-1:0] eq;
      for (genvar gj = 0; gj < gl; gj++) begin : g_byte
        assign eq[gj] = fold_byte(win_i[gl-1-gj], fold_en_i)
                        == fold_byte(needle_i[8*gj +: 8], fold_en_i);
      end
      assign hit_len[gl] = &eq;
    end else begin : g_off
      assign hit_len[gl] = 1'b0;
    end
  end

  assign hit_o = hit_len[len_i];

endmodule

`default_nettype wire

[rtl/core/substring_search_case_fold_core.sv]
// Top level of the streaming case-folding substring search core.
// Streams text one byte per beat (last_byte set on the final byte) and reports,
// once per text, either the start position of the first needle match at or
// after start_position, or found=0 with position zero when the text ends
// without one. The block sustains one byte per clock while out_ready keeps the
// result register draining; a byte is held in the input register while the
// whole window is compared against the needle in parallel, and its result is
// written to the output register, which drives out_valid. in_ready follows
// out_ready in the same cycle only when both registers are full. Bytes after a
// match are absorbed without results until the last byte, which rearms the
// search. The position counter saturates at 2^POS_BITS-1. Write configuration
// only while idle; ASCII A-Z fold to lower case unless the exact-match register
// is set (its reset value is 1).
`default_nettype none

`include "substring_search_case_fold_core_assert.svh"

module substring_search_case_fold_core
  import sscf_pkg::*;
#(
  parameter int MAX_NEEDLE = 16,
  parameter int POS_BITS   = 32
) (
  input  var logic                  clk,
  input  var logic                  rst_n,
  // text byte channel
  input  var logic                  in_valid,
  output logic                      in_ready,
  input  var in_item_t              in_data,
  // result channel
  output logic                      out_valid,
  input  var logic                  out_ready,
  output out_item_t                 out_data,
  // configuration writes
  input  var logic                  cfg_wr_en,
  input  var logic [CFG_IDX_W-1:0]  cfg_index,
  input  var logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Besides the current byte, only the newest 15 bytes can line up with a 16-byte needle.
  localparam int WIN_D   = (MAX_NEEDLE > NEEDLE_BYTES) ? NEEDLE_BYTES - 1 :
                           ((MAX_NEEDLE > 1) ? MAX_NEEDLE - 1 : 1);
  localparam int CMP_W   = (POS_BITS + 1 > RES_POS_W) ? POS_BITS + 1 : RES_POS_W;
  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

  // Configuration registers.
  logic [63:0]          ndl_low_r,  ndl_low_nxt;
  logic [63:0]          ndl_high_r, ndl_high_nxt;
  logic [LEN_W-1:0]     ndl_len_r,  ndl_len_nxt;
  logic                 case_sens_r, case_sens_nxt;
  logic [RES_POS_W-1:0] start_pos_r, start_pos_nxt;

  // Input register.
  logic     in_vld_r, in_vld_nxt;
  in_item_t in_item_r, in_item_nxt;

  // Per-text search state.
  logic [7:0]          win_r [WIN_D];
  logic [7:0]          win_nxt [WIN_D];
  logic [POS_BITS-1:0] pos_r, pos_nxt;
  logic                rep_r, rep_nxt;

  // Result register.
  logic      out_vld_r, out_vld_nxt;
  out_item_t out_item_r, out_item_nxt;

  logic            adv;
  logic [7:0]      cmp_win [WIN_D+1];
  logic            pattern_hit;
  logic [POS_BITS:0] pos_plus1;
  logic [POS_BITS:0] len_ext;
  logic [CMP_W-1:0]  start_cand;
  logic            room_ok;
  logic            start_ok;
  logic            hit;
  logic            res_vld;
  out_item_t       res;

  // ---------------------------------------------------------------------------
  // Configuration decode.
  // ---------------------------------------------------------------------------
  always_comb begin
    ndl_low_nxt   = ndl_low_r;
    ndl_high_nxt  = ndl_high_r;
    ndl_len_nxt   = ndl_len_r;
    case_sens_nxt = case_sens_r;
    start_pos_nxt = start_pos_r;
    if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_NEEDLE_LOW:     ndl_low_nxt   = cfg_wdata;
        CFG_NEEDLE_HIGH:    ndl_high_nxt  = cfg_wdata;
        CFG_NEEDLE_LENGTH:  ndl_len_nxt   = cfg_wdata[LEN_W-1:0];
        CFG_EXACT_MATCH:    case_sens_nxt = cfg_wdata[0];
        CFG_START_POSITION: start_pos_nxt = cfg_wdata[RES_POS_W-1:0];
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ndl_low_r   <= '0;
      ndl_high_r  <= '0;
      ndl_len_r   <= '0;
      case_sens_r <= 1'b1;
      start_pos_r <= '0;
    end else begin
      ndl_low_r   <= ndl_low_nxt;
      ndl_high_r  <= ndl_high_nxt;
      ndl_len_r   <= ndl_len_nxt;
      case_sens_r <= case_sens_nxt;
      start_pos_r <= start_pos_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake: advance the held byte whenever the result register can take
  // its result (empty, or draining this cycle).
  // ---------------------------------------------------------------------------
  assign adv      = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || adv;

  always_comb begin
    in_vld_nxt  = in_vld_r;
    in_item_nxt = in_item_r;
    if (in_valid && in_ready) begin
      in_vld_nxt  = 1'b1;
      in_item_nxt = in_data;
    end else if (adv) begin
      in_vld_nxt  = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Match evaluation for the held byte.
  // ---------------------------------------------------------------------------
  always_comb begin
    cmp_win[0] = in_item_r.text_byte;
    for (int i = 0; i < WIN_D; i++) begin
      cmp_win[i+1] = win_r[i];
    end
  end

  sscf_match #(
    .MAX_NEEDLE (MAX_NEEDLE),
    .WIN_D      (WIN_D)
  ) u_match (
    .win_i     (cmp_win),
    .needle_i  ({ndl_high_r, ndl_low_r}),
    .len_i     (ndl_len_r),
    .fold_en_i (!case_sens_r),
    .hit_o     (pattern_hit)
  );

  // The match would start at pos+1-len: it must lie inside the text and at
  // or after the configured start.
  assign pos_plus1  = {1'b0, pos_r} + {{POS_BITS{1'b0}}, 1'b1};
  assign len_ext    = (POS_BITS+1)'(ndl_len_r);
  assign room_ok    = pos_plus1 >= len_ext;
  assign start_cand = CMP_W'(pos_plus1 - len_ext);
  assign start_ok   = start_cand >= CMP_W'(start_pos_r);

  assign hit     = !rep_r && pattern_hit && room_ok && start_ok;
  assign res_vld = hit || (in_item_r.last_byte && !rep_r);

  always_comb begin
    res.found          = hit;
    res.match_position = hit ? start_cand[RES_POS_W-1:0] : '0;
  end

  // ---------------------------------------------------------------------------
  // Search state: shift the window and count positions; the last byte clears
  // everything for the next text.
  // ---------------------------------------------------------------------------
  always_comb begin
    win_nxt = win_r;
    pos_nxt = pos_r;
    rep_nxt = rep_r;
    if (adv) begin
      if (in_item_r.last_byte) begin
        for (int i = 0; i < WIN_D; i++) begin
          win_nxt[i] = '0;
        end
        pos_nxt = '0;
        rep_nxt = 1'b0;
      end else begin
        win_nxt[0] = in_item_r.text_byte;
        for (int i = 1; i < WIN_D; i++) begin
          win_nxt[i] = win_r[i-1];
        end
        if (pos_r != POS_MAX) begin
          pos_nxt = pos_r + POS_BITS'(1);
        end
        rep_nxt = rep_r || hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WIN_D; i++) begin
        win_r[i] <= '0;
      end
      pos_r <= '0;
      rep_r <= 1'b0;
    end else begin
      win_r <= win_nxt;
      pos_r <= pos_nxt;
      rep_r <= rep_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register: load on a producing advance, drop when taken.
  // ---------------------------------------------------------------------------
  always_comb begin
    out_vld_nxt  = out_vld_r && !out_ready;
    out_item_nxt = out_item_r;
    if (adv) begin
      out_vld_nxt = res_vld;
      if (res_vld) begin
        out_item_nxt = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_item_r  <= in_item_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_item_r;

  // ---------------------------------------------------------------------------
  // Checks.
  // ---------------------------------------------------------------------------
  `SSCF_ASSERT_NEXT(a_last_rearms, adv && in_item_r.last_byte, (pos_r == '0) && !rep_r)
  `SSCF_ASSERT_NEXT(a_pos_saturates, adv && !in_item_r.last_byte && (pos_r == POS_MAX),
                    pos_r == POS_MAX)
  `SSCF_ASSERT_NOW(a_empty_needle_misses, res_vld && (ndl_len_r == '0), !res.found)
  `SSCF_ASSERT_NEXT(a_found_marks_text, adv && hit && !in_item_r.last_byte,
                    rep_r && out_vld_r && out_item_r.found)

endmodule

`default_nettype wire
